// File: sv/gha_pkg.sv
// shared types and constants of the generational handle allocator
package gha_pkg;

  localparam int OP_W      = 3;
  localparam int SLOT_ID_W = 6;
  localparam int GEN_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_CHECK   = 3'd1;
  localparam logic [OP_W-1:0] OP_DESTROY = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  typedef enum logic [2:0] {
    K_CREATE,
    K_CHECK,
    K_DESTROY,
    K_CLEAR,
    K_LIST,
    K_BAD
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [GEN_W-1:0]     generation;
    logic                 slot_fits;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_ID_W-1:0] out_slot;
    logic [GEN_W-1:0]     out_generation;
    logic                 handle_ok;
    logic [COUNT_W-1:0]   live_count;
    logic                 last;
  } res_t;

endpackage

// File: sv/gha_if.sv
// request and result channel interfaces of the handle allocator
interface gha_in_if;
  logic                           valid;
  logic                           ready;
  logic [gha_pkg::OP_W-1:0]      operation;
  logic [gha_pkg::SLOT_ID_W-1:0] slot_id;
  logic [gha_pkg::GEN_W-1:0]     generation;

  modport source (output valid, output operation, output slot_id, output generation,
                  input ready);
  modport sink (input valid, input operation, input slot_id, input generation,
                output ready);
endinterface

interface gha_out_if;
  logic                           valid;
  logic                           ready;
  logic [gha_pkg::STATUS_W-1:0]  status;
  logic [gha_pkg::SLOT_ID_W-1:0] out_slot;
  logic [gha_pkg::GEN_W-1:0]     out_generation;
  logic                           handle_ok;
  logic [gha_pkg::COUNT_W-1:0]   live_count;
  logic                           last;

  modport source (output valid, output status, output out_slot, output out_generation,
                  output handle_ok, output live_count, output last, input ready);
  modport sink (input valid, input status, input out_slot, input out_generation,
                input handle_ok, input live_count, input last, output ready);
endinterface

// File: sv/gha_ram.sv
// generic single-write, single-read ram with registered read data
module gha_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/gha_fifo.sv
// short command queue between the front and back parts
module gha_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: sv/gha_front.sv
// request decoder: classifies the operation and checks the slot range
module gha_front #(
  parameter int CAPACITY = 64
) (
  gha_in_if.sink          request,
  output logic            push_valid,
  input  logic            push_ready,
  output gha_pkg::cmd_t   push_cmd
);

  assign push_valid    = request.valid;
  assign request.ready = push_ready;

  always_comb begin
    case (request.operation)
      gha_pkg::OP_CREATE:  push_cmd.kind = gha_pkg::K_CREATE;
      gha_pkg::OP_CHECK:   push_cmd.kind = gha_pkg::K_CHECK;
      gha_pkg::OP_DESTROY: push_cmd.kind = gha_pkg::K_DESTROY;
      gha_pkg::OP_CLEAR:   push_cmd.kind = gha_pkg::K_CLEAR;
      gha_pkg::OP_LIST:    push_cmd.kind = gha_pkg::K_LIST;
      default:             push_cmd.kind = gha_pkg::K_BAD;
    endcase
    push_cmd.slot_id    = request.slot_id;
    push_cmd.generation = request.generation;
    push_cmd.slot_fits  = (32'(request.slot_id) < 32'(CAPACITY));
  end

endmodule

// File: sv/gha_back.sv
// execution sequencer: slot table, free stack, counters and result register
module gha_back #(
  parameter int CAPACITY = 64,
  parameter int GEN_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  gha_pkg::cmd_t cmd,
  gha_out_if.source     result
);

  localparam int SW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int TW    = GEN_BITS + 1;
  localparam int SID_W = gha_pkg::SLOT_ID_W;
  localparam int OG_W  = gha_pkg::GEN_W;
  localparam int CNT_W = gha_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_CRE,
    S_HANDLE,
    S_CLEAR,
    S_LIST
  } state_t;

  state_t              state, state_next;
  gha_pkg::cmd_t       cur, cur_next;
  logic [CW-1:0]       free_depth, free_depth_next;
  logic [CW-1:0]       high_water, high_water_next;
  logic [CW-1:0]       live_total, live_total_next;
  logic [SW-1:0]       slot_r, slot_r_next;
  logic [CW-1:0]       scan_idx, scan_idx_next;
  logic                pend, pend_next;
  logic [SW-1:0]       pend_idx, pend_idx_next;
  logic                held_v, held_v_next;
  logic [SW-1:0]       held_slot, held_slot_next;
  logic [GEN_BITS-1:0] held_gen, held_gen_next;
  logic                out_valid, out_valid_next;
  gha_pkg::res_t       out_res, out_res_next;

  logic                tbl_we, tbl_re;
  logic [SW-1:0]       tbl_waddr, tbl_raddr;
  logic [TW-1:0]       tbl_wdata, tbl_rdata;
  logic                stk_we, stk_re;
  logic [SW-1:0]       stk_waddr, stk_raddr;
  logic [SW-1:0]       stk_wdata, stk_rdata;

  logic                tbl_live;
  logic [GEN_BITS-1:0] tbl_gen;
  logic [GEN_BITS-1:0] gen_inc;
  logic                out_free;
  logic                emit;
  gha_pkg::res_t       emit_res;
  logic                handle_ok;
  logic                scan_go;
  logic                scan_end;
  logic [CW-1:0]       depth_m1;

  gha_ram #(.W(TW), .DEPTH(CAPACITY)) u_slot_tbl (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_en   (tbl_re),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  gha_ram #(.W(SW), .DEPTH(CAPACITY)) u_free_stk (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_en   (stk_re),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  assign tbl_live  = tbl_rdata[GEN_BITS];
  assign tbl_gen   = tbl_rdata[GEN_BITS-1:0];
  assign gen_inc   = tbl_gen + GEN_BITS'(1);
  assign out_free  = !out_valid || result.ready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign handle_ok = tbl_live && (tbl_gen == GEN_BITS'(cur.generation));
  assign scan_end  = !pend && (scan_idx >= high_water);
  assign depth_m1  = free_depth - CW'(1);

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    free_depth_next = free_depth;
    high_water_next = high_water;
    live_total_next = live_total;
    slot_r_next     = slot_r;
    scan_idx_next   = scan_idx;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    held_v_next     = held_v;
    held_slot_next  = held_slot;
    held_gen_next   = held_gen;
    tbl_we          = 1'b0;
    tbl_waddr       = '0;
    tbl_wdata       = '0;
    tbl_re          = 1'b0;
    tbl_raddr       = '0;
    stk_we          = 1'b0;
    stk_waddr       = free_depth[SW-1:0];
    stk_wdata       = '0;
    stk_re          = 1'b0;
    stk_raddr       = depth_m1[SW-1:0];
    emit            = 1'b0;
    emit_res        = '0;
    emit_res.last   = 1'b1;
    scan_go         = 1'b0;

    case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cur_next = cmd;
          case (cmd.kind)
            gha_pkg::K_CREATE: begin
              if (free_depth != '0) begin
                stk_re          = 1'b1;
                free_depth_next = depth_m1;
                state_next      = S_POP;
              end else if (high_water < CW'(CAPACITY)) begin
                tbl_we          = 1'b1;
                tbl_waddr       = high_water[SW-1:0];
                tbl_wdata       = {1'b1, GEN_BITS'(0)};
                high_water_next = high_water + CW'(1);
                live_total_next = live_total + CW'(1);
                emit            = 1'b1;
                emit_res.status = gha_pkg::ST_OK;
                emit_res.out_slot = SID_W'(high_water);
              end else begin
                emit            = 1'b1;
                emit_res.status = gha_pkg::ST_FULL;
              end
            end
            gha_pkg::K_CHECK, gha_pkg::K_DESTROY: begin
              if (cmd.slot_fits && (32'(cmd.slot_id) < 32'(high_water))) begin
                tbl_re     = 1'b1;
                tbl_raddr  = SW'(cmd.slot_id);
                state_next = S_HANDLE;
              end else begin
                emit              = 1'b1;
                emit_res.status   = gha_pkg::ST_INVALID;
                emit_res.out_slot = cmd.slot_id;
              end
            end
            gha_pkg::K_CLEAR, gha_pkg::K_LIST: begin
              scan_idx_next = '0;
              pend_next     = 1'b0;
              held_v_next   = 1'b0;
              state_next    = (cmd.kind == gha_pkg::K_CLEAR) ? S_CLEAR : S_LIST;
            end
            default: begin
              emit            = 1'b1;
              emit_res.status = gha_pkg::ST_INVALID;
            end
          endcase
        end
      end

      S_POP: begin
        slot_r_next = stk_rdata;
        tbl_re      = 1'b1;
        tbl_raddr   = stk_rdata;
        state_next  = S_CRE;
      end

      S_CRE: begin
        if (out_free) begin
          tbl_we                  = 1'b1;
          tbl_waddr               = slot_r;
          tbl_wdata               = {1'b1, tbl_gen};
          live_total_next         = live_total + CW'(1);
          emit                    = 1'b1;
          emit_res.status         = gha_pkg::ST_OK;
          emit_res.out_slot       = SID_W'(slot_r);
          emit_res.out_generation = OG_W'(tbl_gen);
          state_next              = S_IDLE;
        end
      end

      S_HANDLE: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_res.status         = handle_ok ? gha_pkg::ST_OK : gha_pkg::ST_INVALID;
          emit_res.handle_ok      = handle_ok;
          emit_res.out_slot       = cur.slot_id;
          emit_res.out_generation = OG_W'(tbl_gen);
          if ((cur.kind == gha_pkg::K_DESTROY) && handle_ok) begin
            tbl_we                  = 1'b1;
            tbl_waddr               = SW'(cur.slot_id);
            tbl_wdata               = {1'b0, gen_inc};
            emit_res.out_generation = OG_W'(gen_inc);
            if (live_total != '0) begin
              live_total_next = live_total - CW'(1);
            end
            if (free_depth < CW'(CAPACITY)) begin
              stk_we          = 1'b1;
              stk_wdata       = SW'(cur.slot_id);
              free_depth_next = free_depth + CW'(1);
            end
          end
          state_next = S_IDLE;
        end
      end

      S_CLEAR: begin
        scan_go = 1'b1;
        if (pend && tbl_live) begin
          tbl_we    = 1'b1;
          tbl_waddr = pend_idx;
          tbl_wdata = {1'b0, gen_inc};
          if (free_depth < CW'(CAPACITY)) begin
            stk_we          = 1'b1;
            stk_wdata       = pend_idx;
            free_depth_next = free_depth + CW'(1);
          end
        end
        if (scan_end && out_free) begin
          live_total_next = '0;
          emit            = 1'b1;
          emit_res.status = gha_pkg::ST_OK;
          state_next      = S_IDLE;
        end
      end

      S_LIST: begin
        scan_go = !(pend && tbl_live && held_v) || out_free;
        if (scan_go && pend && tbl_live) begin
          if (held_v) begin
            emit                    = 1'b1;
            emit_res.status         = gha_pkg::ST_OK;
            emit_res.out_slot       = SID_W'(held_slot);
            emit_res.out_generation = OG_W'(held_gen);
            emit_res.last           = 1'b0;
          end
          held_v_next    = 1'b1;
          held_slot_next = pend_idx;
          held_gen_next  = tbl_gen;
        end
        if (scan_end && out_free) begin
          emit = 1'b1;
          if (held_v) begin
            emit_res.status         = gha_pkg::ST_OK;
            emit_res.out_slot       = SID_W'(held_slot);
            emit_res.out_generation = OG_W'(held_gen);
          end else begin
            emit_res.status = gha_pkg::ST_EMPTY;
          end
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (scan_go) begin
      if (scan_idx < high_water) begin
        tbl_re        = 1'b1;
        tbl_raddr     = scan_idx[SW-1:0];
        pend_idx_next = scan_idx[SW-1:0];
        scan_idx_next = scan_idx + CW'(1);
        pend_next     = 1'b1;
      end else begin
        pend_next = 1'b0;
      end
    end

    emit_res.live_count = CNT_W'(live_total_next);

    out_res_next   = out_res;
    out_valid_next = out_valid;
    if (emit) begin
      out_valid_next = 1'b1;
      out_res_next   = emit_res;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    slot_r    <= slot_r_next;
    pend_idx  <= pend_idx_next;
    held_slot <= held_slot_next;
    held_gen  <= held_gen_next;
    out_res   <= out_res_next;
    if (rst) begin
      state      <= S_IDLE;
      free_depth <= '0;
      high_water <= '0;
      live_total <= '0;
      scan_idx   <= '0;
      pend       <= 1'b0;
      held_v     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      free_depth <= free_depth_next;
      high_water <= high_water_next;
      live_total <= live_total_next;
      scan_idx   <= scan_idx_next;
      pend       <= pend_next;
      held_v     <= held_v_next;
      out_valid  <= out_valid_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = out_res.status;
  assign result.out_slot       = out_res.out_slot;
  assign result.out_generation = out_res.out_generation;
  assign result.handle_ok      = out_res.handle_ok;
  assign result.live_count     = out_res.live_count;
  assign result.last           = out_res.last;

endmodule

// File: sv/generational_handle_allocator.sv
// generational handle allocator top level
//
// request channel: operation, slot_id, generation (create, check, destroy,
// clear all, list live). result channel: status, out_slot, out_generation,
// handle_ok, live_count, last; last marks the final result of a request.
// requests enter a two-entry command queue and are carried out one at a time
// by a sequencer around the slot table and free stack rams, each with one
// write and one registered read port.
// handling once a command reaches the queue head: create of a never-used
// slot, full table, out-of-range handle and unknown op are answered straight
// from idle; check and destroy take one slot table read; create of a freed
// slot takes a stack read, then a slot table read. clear and list walk the
// slots below the high-water mark, one slot table read per cycle, though list
// holds its walk while a result waits in the output register and is not taken.
// reset empties the table (no clearing pass); results sit in an output
// register, and a stalled receiver holds the sequencer while the queue keeps
// accepting requests until full.
module generational_handle_allocator #(
  parameter int CAPACITY = 64,
  parameter int GEN_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  gha_in_if.sink    request,
  gha_out_if.source result
);

  localparam int CMD_W = $bits(gha_pkg::cmd_t);

  logic          q_push_valid;
  logic          q_push_ready;
  gha_pkg::cmd_t q_push_cmd;
  logic          q_pop_valid;
  logic          q_pop_ready;
  gha_pkg::cmd_t q_pop_cmd;

  gha_front #(.CAPACITY(CAPACITY)) u_front (
    .request    (request),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd)
  );

  gha_fifo #(.W(CMD_W), .DEPTH(gha_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_cmd)
  );

  gha_back #(.CAPACITY(CAPACITY), .GEN_BITS(GEN_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_pop_valid),
    .cmd_ready (q_pop_ready),
    .cmd       (q_pop_cmd),
    .result    (result)
  );

`ifndef ASSERT_OFF
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == gha_pkg::ST_FULL)
      |-> (result.live_count == gha_pkg::COUNT_W'(CAPACITY)) && !result.handle_ok)
    else $error("full reported while slots are free");

  a_empty_list: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == gha_pkg::ST_EMPTY)
      |-> result.last && (result.live_count == '0))
    else $error("empty list with live slots");

  a_handle_ok: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.handle_ok
      |-> (result.status == gha_pkg::ST_OK) && result.last)
    else $error("valid handle with bad status");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready
      |=> result.valid && $stable({result.status, result.out_slot, result.out_generation,
                                   result.handle_ok, result.live_count, result.last}))
    else $error("result transaction changed while stalled");
`endif

endmodule
